// ----- design/dpps_pkg.sv -----
// ----------------------------------------------------------------------------
// dpps_pkg
// Shared types and constants for the depth point projection splatter.
// ----------------------------------------------------------------------------
package dpps_pkg;

    // Store and window geometry
    localparam int MAX_PIXELS    = 131072;
    localparam int WINDOW_RADIUS = 7;
    localparam int WIN_SPAN      = 2 * WINDOW_RADIUS + 1;
    localparam int WIN_CNT_W     = $clog2(WIN_SPAN + 1);
    localparam int ADDR_W        = $clog2(MAX_PIXELS);

    // Transform and arithmetic
    localparam int NUM_ENTRIES = 12;
    localparam int Q_SHIFT     = 14;
    localparam int C_W         = 34;   // transformed coordinate, mm in Q.14
    localparam int PROD_W      = 47;   // focal/center times coordinate
    localparam int NUM_W       = 48;   // projection numerator
    localparam int DIV_W       = 47;   // numerator magnitude bits
    localparam int DIV_CNT_W   = 6;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FOCAL_X      = 3'd2;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd3;
    localparam logic [2:0] REG_CENTER_X     = 3'd4;
    localparam logic [2:0] REG_CENTER_Y     = 3'd5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SPLAT = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_XFORM,
        ST_PROJ,
        ST_DIV,
        ST_WIN_SETUP,
        ST_WIN_BASE,
        ST_WIN,
        ST_READ,
        ST_READ_DATA
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         entry_index;
        logic signed [15:0] entry_value;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [16:0]        read_index;
    } item_t;

    typedef struct packed {
        logic [9:0]  frame_width;
        logic [8:0]  frame_height;
        logic [11:0] focal_x;
        logic [11:0] focal_y;
        logic [11:0] center_x;
        logic [11:0] center_y;
    } cfg_t;

endpackage

// ----- design/depth_point_project_splat_core.sv -----
// ----------------------------------------------------------------------------
// depth_point_project_splat_core
// Depth image store with a pinhole point projector and window splatter.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel; tuser carries the operation
//   (clear, load transform entry, splat point, read pixel) and tdata the
//   operands. Only a read returns a result on m_axis: the stored depth and
//   the echoed pixel index. The APB port sets frame size, focal lengths and
//   principal point, and must be written only while the block is idle.
//   A two-entry request queue decouples intake from execution, so requests
//   are taken while the back end works; requests execute in order.
//   In the back end a clear writes one store entry per cycle, and a splat
//   runs the transform, the projection multiplies and two 47-bit serial
//   divides, then a window setup and a walk over the 15 by 15 window; the
//   single store write port and the bit-serial divider set the pace.
//   Reset empties the queue, clears the transform and the result valid flag
//   and restores default registers; the depth image holds no defined value
//   until cleared or written. A stalled receiver holds the result; a read
//   then waits at the head of the queue, the requests behind it wait too,
//   and intake stops once the queue is full.
// ----------------------------------------------------------------------------
module depth_point_project_splat_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] entry_index, [19:4] entry_value, [35:20] point_x,
    // [51:36] point_y, [67:52] point_z, [84:68] read_index, [87:85] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] depth_mm, [32:16] pixel_echo, [39:33] zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dpps_pkg::cfg_t  cfg_reg;
    dpps_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 10'd320;
            cfg_reg.frame_height <= 9'd240;
            cfg_reg.focal_x      <= 12'd256;
            cfg_reg.focal_y      <= 12'd256;
            cfg_reg.center_x     <= 12'd160;
            cfg_reg.center_y     <= 12'd120;
        end
        else if (cfg_wr && (paddr[1:0] == 2'b00))
        begin
            case (paddr[4:2])
                dpps_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[9:0];
                dpps_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[8:0];
                dpps_pkg::REG_FOCAL_X:      cfg_reg.focal_x      <= pwdata[11:0];
                dpps_pkg::REG_FOCAL_Y:      cfg_reg.focal_y      <= pwdata[11:0];
                dpps_pkg::REG_CENTER_X:     cfg_reg.center_x     <= pwdata[11:0];
                dpps_pkg::REG_CENTER_Y:     cfg_reg.center_y     <= pwdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[4:2])
            dpps_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            dpps_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            dpps_pkg::REG_FOCAL_X:      prdata = 32'(cfg_reg.focal_x);
            dpps_pkg::REG_FOCAL_Y:      prdata = 32'(cfg_reg.focal_y);
            dpps_pkg::REG_CENTER_X:     prdata = 32'(cfg_reg.center_x);
            dpps_pkg::REG_CENTER_Y:     prdata = 32'(cfg_reg.center_y);
            default:                    prdata = 32'd0;
        endcase
    end

    dpps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop)
    );

    dpps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- design/dpps_front.sv -----
// ----------------------------------------------------------------------------
// dpps_front
// Accepts stream requests, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module dpps_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, entry_value, point_x, point_y, point_z, read_index, pad
    input  logic [87:0]           s_axis_tdata,
    // operation
    input  logic [1:0]            s_axis_tuser,
    output dpps_pkg::item_t       q_item,
    output logic                  q_valid,
    input  logic                  q_pop
);

    dpps_pkg::item_t              queue_reg [dpps_pkg::QUEUE_DEPTH];
    logic [dpps_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [dpps_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [dpps_pkg::QCNT_W-1:0]  count_reg, count_next;
    dpps_pkg::item_t              dec_item;
    logic                         accept;
    logic                         push;

    // Field unpacking
    always_comb
    begin
        dec_item.op          = dpps_pkg::op_t'(s_axis_tuser);
        dec_item.entry_index = s_axis_tdata[3:0];
        dec_item.entry_value = s_axis_tdata[19:4];
        dec_item.point_x     = s_axis_tdata[35:20];
        dec_item.point_y     = s_axis_tdata[51:36];
        dec_item.point_z     = s_axis_tdata[67:52];
        dec_item.read_index  = s_axis_tdata[84:68];
    end

    assign s_axis_tready = (count_reg != dpps_pkg::QCNT_W'(dpps_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Loads to entries past the transform are dropped here
    assign push = accept && !((dec_item.op == dpps_pkg::OP_LOAD) &&
                  (dec_item.entry_index >= 4'(dpps_pkg::NUM_ENTRIES)));

    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

// ----- design/dpps_back.sv -----
// ----------------------------------------------------------------------------
// dpps_back
// Executes queued requests: clear sweep, transform load, splat, pixel read.
// ----------------------------------------------------------------------------
module dpps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dpps_pkg::cfg_t    cfg,
    input  dpps_pkg::item_t   q_item,
    input  logic              q_valid,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // depth_mm, pixel_echo, pad
    output logic [39:0]       m_axis_tdata
);

    localparam int A = dpps_pkg::ADDR_W;
    localparam int W = dpps_pkg::WIN_CNT_W;

    dpps_pkg::state_t state_reg, state_next;

    // Transform and splat datapath
    logic signed [15:0]                 t_reg [dpps_pkg::NUM_ENTRIES];
    logic signed [15:0]                 px_reg, py_reg, pz_reg;
    logic signed [dpps_pkg::C_W-1:0]    c_reg [3];
    logic [3:0]                         step_reg;
    logic [1:0]                         j_reg, k_reg;
    logic                               phase_reg;
    logic signed [31:0]                 prod16_reg;
    logic signed [dpps_pkg::PROD_W-1:0] prod_p_reg;
    logic signed [dpps_pkg::NUM_W-1:0]  numx_reg, numy_reg;
    logic [15:0]                        depth_reg;

    // Divider
    logic [dpps_pkg::DIV_W-1:0]         dvd_reg, quot_reg;
    logic [dpps_pkg::C_W-1:0]           rem_reg;
    logic [dpps_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic                               div_sel_reg;
    logic                               neg_reg;

    // Window walk
    logic [9:0]                         col_reg;
    logic [8:0]                         row_reg;
    logic signed [21:0]                 rowoff_reg;
    logic [A:0]                         size_reg;
    logic signed [21:0]                 idx_reg, colbase_reg;
    logic [W-1:0]                       a_cnt_reg, b_cnt_reg;

    // Clear, read and memory
    logic [A-1:0]                       clr_cnt_reg;
    logic [16:0]                        rd_index_reg;
    logic [15:0]                        rd_data_reg;
    logic [15:0]                        mem [dpps_pkg::MAX_PIXELS];
    logic                               mem_we;
    logic [A-1:0]                       mem_waddr;

    logic                               out_valid_reg;
    logic [15:0]                        out_depth_reg;
    logic [16:0]                        out_echo_reg;

    // Combinational helpers
    logic signed [15:0]                 pmux;
    logic signed [12:0]                 kmul;
    logic signed [dpps_pkg::C_W-1:0]    cmul;
    logic [dpps_pkg::C_W-1:0]           rem_shift;
    logic [dpps_pkg::C_W-1:0]           divisor;
    logic                               rem_ge;
    logic                               div_ok;
    logic [dpps_pkg::C_W-1:0]           dz_sum;
    logic                               win_hit;
    logic                               b_last, a_last;
    logic [18:0]                        wh;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_echo_reg, out_depth_reg};

    // Operand selection for the shared multipliers
    always_comb
    begin
        case (j_reg)
            2'd0:    pmux = px_reg;
            2'd1:    pmux = py_reg;
            default: pmux = pz_reg;
        endcase
        case (step_reg[1:0])
            2'd0:
            begin
                kmul = $signed({1'b0, cfg.focal_x});
                cmul = c_reg[0];
            end
            2'd1:
            begin
                kmul = $signed({1'b0, cfg.center_x});
                cmul = c_reg[2];
            end
            2'd2:
            begin
                kmul = $signed({1'b0, cfg.focal_y});
                cmul = c_reg[1];
            end
            default:
            begin
                kmul = $signed({1'b0, cfg.center_y});
                cmul = c_reg[2];
            end
        endcase
    end

    // Divider step and result check
    always_comb
    begin
        divisor   = c_reg[2];
        rem_shift = {rem_reg[dpps_pkg::C_W-2:0], dvd_reg[dpps_pkg::DIV_W-1]};
        rem_ge    = (rem_shift >= divisor);
        if (neg_reg && (quot_reg != '0))
        begin
            div_ok = 1'b0;
        end
        else if (div_sel_reg)
        begin
            div_ok = (quot_reg <= dpps_pkg::DIV_W'(cfg.frame_height));
        end
        else
        begin
            div_ok = (quot_reg <= dpps_pkg::DIV_W'(cfg.frame_width));
        end
        dz_sum = c_reg[2] + dpps_pkg::C_W'(1 << (dpps_pkg::Q_SHIFT - 1));
        wh     = cfg.frame_width * cfg.frame_height;
    end

    // Window bounds and memory write port
    assign win_hit = (idx_reg > 22'sd0) &&
                     (idx_reg < $signed({1'b0, 21'(size_reg)}));
    assign b_last  = (b_cnt_reg == W'(dpps_pkg::WIN_SPAN - 1));
    assign a_last  = (a_cnt_reg == W'(dpps_pkg::WIN_SPAN - 1));
    assign mem_we  = ((state_reg == dpps_pkg::ST_WIN) && win_hit) ||
                     (state_reg == dpps_pkg::ST_CLEAR);
    assign mem_waddr = (state_reg == dpps_pkg::ST_CLEAR) ? clr_cnt_reg : A'(idx_reg);

    // Next state and queue pop
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            dpps_pkg::ST_IDLE:
            begin
                if (q_valid && !((q_item.op == dpps_pkg::OP_READ) && out_valid_reg))
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        dpps_pkg::OP_CLEAR: state_next = dpps_pkg::ST_CLEAR;
                        dpps_pkg::OP_SPLAT: state_next = dpps_pkg::ST_XFORM;
                        dpps_pkg::OP_READ:  state_next = dpps_pkg::ST_READ;
                        default:            state_next = dpps_pkg::ST_IDLE;
                    endcase
                end
            end
            dpps_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == A'(dpps_pkg::MAX_PIXELS - 1))
                begin
                    state_next = dpps_pkg::ST_IDLE;
                end
            end
            dpps_pkg::ST_XFORM:
            begin
                if (phase_reg && (step_reg == 4'd8))
                begin
                    state_next = dpps_pkg::ST_PROJ;
                end
            end
            dpps_pkg::ST_PROJ:
            begin
                if (c_reg[2] <= 0)
                begin
                    state_next = dpps_pkg::ST_IDLE;
                end
                else if (phase_reg && (step_reg[1:0] == 2'd3))
                begin
                    state_next = dpps_pkg::ST_DIV;
                end
            end
            dpps_pkg::ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    if (!div_ok)
                    begin
                        state_next = dpps_pkg::ST_IDLE;
                    end
                    else if (div_sel_reg)
                    begin
                        state_next = dpps_pkg::ST_WIN_SETUP;
                    end
                end
            end
            dpps_pkg::ST_WIN_SETUP: state_next = dpps_pkg::ST_WIN_BASE;
            dpps_pkg::ST_WIN_BASE:  state_next = dpps_pkg::ST_WIN;
            dpps_pkg::ST_WIN:
            begin
                if (a_last && b_last)
                begin
                    state_next = dpps_pkg::ST_IDLE;
                end
            end
            dpps_pkg::ST_READ:      state_next = dpps_pkg::ST_READ_DATA;
            dpps_pkg::ST_READ_DATA: state_next = dpps_pkg::ST_IDLE;
            default:                state_next = dpps_pkg::ST_IDLE;
        endcase
    end

    // State, transform entries and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < dpps_pkg::NUM_ENTRIES; i++)
            begin
                t_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && (q_item.op == dpps_pkg::OP_LOAD) &&
                (q_item.entry_index < 4'(dpps_pkg::NUM_ENTRIES)))
            begin
                t_reg[q_item.entry_index] <= q_item.entry_value;
            end
            if (state_reg == dpps_pkg::ST_READ_DATA)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath sequencing
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dpps_pkg::ST_IDLE:
            begin
                step_reg     <= '0;
                j_reg        <= '0;
                k_reg        <= '0;
                phase_reg    <= 1'b0;
                clr_cnt_reg  <= '0;
                div_sel_reg  <= 1'b0;
                px_reg       <= q_item.point_x;
                py_reg       <= q_item.point_y;
                pz_reg       <= q_item.point_z;
                rd_index_reg <= q_item.read_index;
                for (int k = 0; k < 3; k++)
                begin
                    c_reg[k] <= dpps_pkg::C_W'(t_reg[9 + k]) <<< dpps_pkg::Q_SHIFT;
                end
            end
            dpps_pkg::ST_CLEAR:
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            // Three dot products, one multiply then one add per term
            dpps_pkg::ST_XFORM:
            begin
                phase_reg <= !phase_reg;
                if (!phase_reg)
                begin
                    prod16_reg <= t_reg[step_reg] * pmux;
                end
                else
                begin
                    c_reg[k_reg] <= c_reg[k_reg] + dpps_pkg::C_W'(prod16_reg);
                    if (step_reg == 4'd8)
                    begin
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                    if (j_reg == 2'd2)
                    begin
                        j_reg <= '0;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end
            // Projection numerators and rounded depth
            dpps_pkg::ST_PROJ:
            begin
                phase_reg <= !phase_reg;
                depth_reg <= (dz_sum[dpps_pkg::C_W-1:30] != '0) ? 16'hFFFF : dz_sum[29:14];
                if (!phase_reg)
                begin
                    prod_p_reg <= kmul * cmul;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg[1:0])
                        2'd0:    numx_reg <= dpps_pkg::NUM_W'(prod_p_reg);
                        2'd1:    numx_reg <= numx_reg + dpps_pkg::NUM_W'(prod_p_reg);
                        2'd2:    numy_reg <= dpps_pkg::NUM_W'(prod_p_reg);
                        default: numy_reg <= numy_reg + dpps_pkg::NUM_W'(prod_p_reg);
                    endcase
                    if (step_reg[1:0] == 2'd3)
                    begin
                        div_cnt_reg <= dpps_pkg::DIV_CNT_W'(dpps_pkg::DIV_W);
                        neg_reg     <= numx_reg[dpps_pkg::NUM_W-1];
                        dvd_reg     <= dpps_pkg::DIV_W'(numx_reg[dpps_pkg::NUM_W-1] ?
                                                        -numx_reg : numx_reg);
                        rem_reg     <= '0;
                        quot_reg    <= '0;
                    end
                end
            end
            // Restoring divide, one quotient bit per cycle
            dpps_pkg::ST_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    dvd_reg     <= dvd_reg << 1;
                    quot_reg    <= {quot_reg[dpps_pkg::DIV_W-2:0], rem_ge};
                    rem_reg     <= rem_ge ? rem_shift - divisor : rem_shift;
                end
                else if (!div_sel_reg)
                begin
                    // column done, start the row divide
                    col_reg     <= quot_reg[9:0];
                    div_sel_reg <= 1'b1;
                    div_cnt_reg <= dpps_pkg::DIV_CNT_W'(dpps_pkg::DIV_W);
                    neg_reg     <= numy_reg[dpps_pkg::NUM_W-1];
                    dvd_reg     <= dpps_pkg::DIV_W'(numy_reg[dpps_pkg::NUM_W-1] ?
                                                    -numy_reg : numy_reg);
                    rem_reg     <= '0;
                    quot_reg    <= '0;
                end
                else
                begin
                    row_reg <= quot_reg[8:0];
                end
            end
            dpps_pkg::ST_WIN_SETUP:
            begin
                rowoff_reg <= ($signed({2'b00, row_reg}) - 11'(dpps_pkg::WINDOW_RADIUS)) *
                              $signed({1'b0, cfg.frame_width});
                if (32'(wh) > dpps_pkg::MAX_PIXELS)
                begin
                    size_reg <= (A + 1)'(dpps_pkg::MAX_PIXELS);
                end
                else
                begin
                    size_reg <= (A + 1)'(wh);
                end
            end
            dpps_pkg::ST_WIN_BASE:
            begin
                colbase_reg <= $signed({12'd0, col_reg}) - 22'(dpps_pkg::WINDOW_RADIUS);
                idx_reg     <= rowoff_reg + $signed({12'd0, col_reg}) -
                               22'(dpps_pkg::WINDOW_RADIUS);
                a_cnt_reg   <= '0;
                b_cnt_reg   <= '0;
            end
            // Walk each window column down its rows
            dpps_pkg::ST_WIN:
            begin
                if (b_last)
                begin
                    b_cnt_reg   <= '0;
                    a_cnt_reg   <= a_cnt_reg + 1'b1;
                    colbase_reg <= colbase_reg + 22'sd1;
                    idx_reg     <= rowoff_reg + colbase_reg + 22'sd1;
                end
                else
                begin
                    b_cnt_reg <= b_cnt_reg + 1'b1;
                    idx_reg   <= idx_reg + $signed({12'd0, cfg.frame_width});
                end
            end
            dpps_pkg::ST_READ_DATA:
            begin
                out_echo_reg  <= rd_index_reg;
                out_depth_reg <= (32'(rd_index_reg) < dpps_pkg::MAX_PIXELS) ?
                                 rd_data_reg : 16'd0;
            end
            default:
            begin
            end
        endcase
    end

    // Depth store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= (state_reg == dpps_pkg::ST_CLEAR) ? 16'd0 : depth_reg;
        end
        rd_data_reg <= mem[A'(rd_index_reg)];
    end

endmodule

// ----- design/dpps_checker.sv -----
// ----------------------------------------------------------------------------
// dpps_checker
// Port-level checks for the depth splatter, bound to the top level.
// ----------------------------------------------------------------------------
module dpps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A read is not started while a result is held, so results never come back to back
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result followed a taken result directly");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Register port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind depth_point_project_splat_core dpps_checker u_dpps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
